// ===== src/adsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types and constants for the linear adsr envelope generator
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEVEL_FRAC_BITS = 30;
    localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
    localparam int DUR_W           = 24;
    localparam int SUS_W           = 31;
    localparam int PHASE_W         = 3;
    localparam int CNT_W           = $clog2(LEVEL_W);
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 31;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = ((LEVEL_W + PHASE_W + 7) / 8) * 8;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

    localparam logic [DUR_W-1:0] ATTACK_RESET  = DUR_W'(480);
    localparam logic [DUR_W-1:0] DECAY_RESET   = DUR_W'(4800);
    localparam logic [DUR_W-1:0] RELEASE_RESET = DUR_W'(4800);
    localparam logic [SUS_W-1:0] SUSTAIN_RESET = SUS_W'(536870912);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_DECAY   = 2'd1,
        CFG_RELEASE = 2'd2,
        CFG_SUSTAIN = 2'd3
    } cfg_index_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        DK_NONE    = 2'd0,
        DK_ATTACK  = 2'd1,
        DK_RELEASE = 2'd2,
        DK_DECAY   = 2'd3
    } div_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_ADV  = 2'd2
    } ctrl_state_t;

endpackage

// ===== src/adsr_envelope_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// linear adsr envelope, one level and phase result per sample tick
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid / tready         tdata: note_on, gate
//  m_axis    out  tvalid / tready         tdata: level, phase
//  cfg       in   cfg_we (no wait)        cfg_index, cfg_data
//
//  a tick that needs a step runs the divider before the level advances:
//  one bit-serial restoring divider resolves one quotient bit per cycle over the
//  31 bit level numerator, then the advance state updates the level
//  a tick that needs no step (gate high in off, sustain or attack, or release
//  already running) skips the divider and goes straight to the advance state
//  s_axis_tready is high only while the control fsm is idle; the result sits
//  in an output register, so a stalled m_axis holds the next tick in the
//  advance cycle until the register frees up
//  rst_n clears envelope state and loads the register defaults at once
//
module adsr_envelope_generator_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [adsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] note_on, [1] gate
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [adsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [30:0] level, [33:31] phase
    input  logic                               cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import adsr_pkg::*;

    // configuration registers
    logic [DUR_W-1:0]   attack_samples_reg;
    logic [DUR_W-1:0]   decay_samples_reg;
    logic [DUR_W-1:0]   release_samples_reg;
    logic [SUS_W-1:0]   sustain_level_reg;

    // envelope state
    logic [LEVEL_W-1:0] env_level_reg,    env_level_next;
    phase_t             env_phase_reg,    env_phase_next;
    logic [LEVEL_W-1:0] attack_step_reg,  attack_step_next;
    logic [LEVEL_W-1:0] release_step_reg, release_step_next;

    // control and divider
    ctrl_state_t        state_reg,    state_next;
    div_kind_t          kind_reg,     kind_next;
    phase_t             mid_phase_reg, mid_phase_next;
    logic [CNT_W-1:0]   cnt_reg,      cnt_next;
    logic [LEVEL_W-1:0] num_reg,      num_next;   // numerator in, quotient out
    logic [DUR_W-1:0]   rem_reg,      rem_next;
    logic [DUR_W-1:0]   den_reg,      den_next;
    logic               nz_reg,       nz_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    phase_t             out_phase_reg, out_phase_next;

    // combinational helpers
    logic               in_note;
    logic               in_gate;
    logic               in_accept;
    phase_t             ph_after_note;
    logic [LEVEL_W-1:0] sus_sat;
    logic [DUR_W:0]     rem_shift;
    logic               rem_ge;
    logic [DUR_W:0]     rem_sub;
    logic [LEVEL_W-1:0] step;
    logic [LEVEL_W-1:0] att_eff;
    logic [LEVEL_W-1:0] rel_eff;
    logic [LEVEL_W:0]   att_sum;
    logic [LEVEL_W:0]   dec_floor;
    logic               out_free;

    assign in_note   = s_axis_tdata[0];
    assign in_gate   = s_axis_tdata[1];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // sustain above full scale saturates
    assign sus_sat = (sustain_level_reg > SUS_W'(FULL_SCALE)) ? FULL_SCALE
                                                             : LEVEL_W'(sustain_level_reg);

    assign ph_after_note = in_note ? PH_ATTACK : env_phase_reg;

    // one restoring division step per cycle
    assign rem_shift = {rem_reg, num_reg[LEVEL_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    // a zero quotient of a nonzero numerator becomes one lsb
    assign step = (num_reg == '0 && nz_reg) ? LEVEL_W'(1) : num_reg;

    assign att_eff   = (kind_reg == DK_ATTACK)  ? step : attack_step_reg;
    assign rel_eff   = (kind_reg == DK_RELEASE) ? step : release_step_reg;
    assign att_sum   = {1'b0, env_level_reg} + {1'b0, att_eff};
    assign dec_floor = {1'b0, sus_sat} + {1'b0, step};

    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - LEVEL_W - PHASE_W)'(0), out_phase_reg, out_level_reg};

    // configuration writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_samples_reg  <= ATTACK_RESET;
            decay_samples_reg   <= DECAY_RESET;
            release_samples_reg <= RELEASE_RESET;
            sustain_level_reg   <= SUSTAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ATTACK:  attack_samples_reg  <= cfg_data[DUR_W-1:0];
                CFG_DECAY:   decay_samples_reg   <= cfg_data[DUR_W-1:0];
                CFG_RELEASE: release_samples_reg <= cfg_data[DUR_W-1:0];
                CFG_SUSTAIN: sustain_level_reg   <= cfg_data[SUS_W-1:0];
                default:     ;
            endcase
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        mid_phase_next    = mid_phase_reg;
        cnt_next          = cnt_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        nz_next           = nz_reg;
        env_level_next    = env_level_reg;
        env_phase_next    = env_phase_reg;
        attack_step_next  = attack_step_reg;
        release_step_next = release_step_reg;
        out_valid_next    = out_valid_reg;
        out_level_next    = out_level_reg;
        out_phase_next    = out_phase_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cnt_next = CNT_W'(LEVEL_W - 1);
                    rem_next = '0;
                    // gate low wins over a note-on in the same tick
                    if (!in_gate && ph_after_note != PH_RELEASE)
                    begin
                        mid_phase_next = PH_RELEASE;
                        kind_next      = DK_RELEASE;
                        num_next       = env_level_reg;
                        den_next       = release_samples_reg;
                    end
                    else if (in_note)
                    begin
                        mid_phase_next = PH_ATTACK;
                        kind_next      = DK_ATTACK;
                        num_next       = FULL_SCALE - env_level_reg;
                        den_next       = attack_samples_reg;
                    end
                    else if (ph_after_note == PH_DECAY)
                    begin
                        mid_phase_next = PH_DECAY;
                        kind_next      = DK_DECAY;
                        num_next       = FULL_SCALE - sus_sat;
                        den_next       = decay_samples_reg;
                    end
                    else
                    begin
                        mid_phase_next = ph_after_note;
                        kind_next      = DK_NONE;
                    end
                    // zero duration counts as one sample
                    if (den_next == '0)
                    begin
                        den_next = DUR_W'(1);
                    end
                    nz_next    = (num_next != '0);
                    state_next = (kind_next == DK_NONE) ? ST_ADV : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? rem_sub[DUR_W-1:0] : rem_shift[DUR_W-1:0];
                num_next = {num_reg[LEVEL_W-2:0], rem_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (out_free)
                begin
                    if (kind_reg == DK_ATTACK)
                    begin
                        attack_step_next = step;
                    end
                    if (kind_reg == DK_RELEASE)
                    begin
                        release_step_next = step;
                    end
                    case (mid_phase_reg)
                        PH_ATTACK:
                        begin
                            if (att_sum >= {1'b0, FULL_SCALE})
                            begin
                                env_level_next = FULL_SCALE;
                                env_phase_next = PH_DECAY;
                            end
                            else
                            begin
                                env_level_next = att_sum[LEVEL_W-1:0];
                                env_phase_next = PH_ATTACK;
                            end
                        end
                        PH_DECAY:
                        begin
                            if ({1'b0, env_level_reg} <= dec_floor)
                            begin
                                env_level_next = sus_sat;
                                env_phase_next = PH_SUSTAIN;
                            end
                            else
                            begin
                                env_level_next = env_level_reg - step;
                                env_phase_next = PH_DECAY;
                            end
                        end
                        PH_SUSTAIN:
                        begin
                            env_level_next = sus_sat;
                            env_phase_next = PH_SUSTAIN;
                        end
                        PH_RELEASE:
                        begin
                            if (env_level_reg <= rel_eff)
                            begin
                                env_level_next = '0;
                                env_phase_next = PH_OFF;
                            end
                            else
                            begin
                                env_level_next = env_level_reg - rel_eff;
                                env_phase_next = PH_RELEASE;
                            end
                        end
                        default:
                        begin
                            env_level_next = '0;
                            env_phase_next = PH_OFF;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_level_next = env_level_next;
                    out_phase_next = env_phase_next;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kind_reg         <= DK_NONE;
            mid_phase_reg    <= PH_OFF;
            cnt_reg          <= '0;
            env_level_reg    <= '0;
            env_phase_reg    <= PH_OFF;
            attack_step_reg  <= '0;
            release_step_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kind_reg         <= kind_next;
            mid_phase_reg    <= mid_phase_next;
            cnt_reg          <= cnt_next;
            env_level_reg    <= env_level_next;
            env_phase_reg    <= env_phase_next;
            attack_step_reg  <= attack_step_next;
            release_step_reg <= release_step_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // divider and result payload
    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        nz_reg        <= nz_next;
        out_level_reg <= out_level_next;
        out_phase_reg <= out_phase_next;
    end

    // checks
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_level_reg <= FULL_SCALE)
        else $error("envelope level above full scale");

    a_off_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        env_phase_reg == PH_OFF |-> env_level_reg == '0)
        else $error("envelope off with nonzero level");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("tick accepted but control stayed idle");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_result_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADV && out_free) |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("advance did not post a result");

endmodule
